>>> hdl/obc_pkg.sv
package obc_pkg;

    localparam int unsigned PulseW = 12;
    localparam int unsigned DistW  = 16;
    localparam int unsigned SpeedW = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [PulseW-1:0] NEUTRAL_PULSE = PulseW'(1500);

    // Configuration reset values.
    localparam logic [DistW-1:0]  RST_OBSTACLE_DISTANCE = DistW'(300);
    localparam logic [DistW-1:0]  RST_NEAR_DISTANCE     = DistW'(150);
    localparam logic [15:0]       RST_REARM_WAIT_MS     = 16'd1000;
    localparam logic [15:0]       RST_POST_HOLD_MS      = 16'd250;
    localparam logic [PulseW-1:0] RST_BRAKE_PULSE_FAR   = PulseW'(1670);
    localparam logic [PulseW-1:0] RST_BRAKE_PULSE_NEAR  = PulseW'(1800);
    localparam logic [15:0]       RST_TRIGGER_SPEED     = 16'd400;
    localparam logic [PulseW-1:0] RST_OVERRIDE_PULSE    = PulseW'(1510);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OBSTACLE_DISTANCE = 3'd0,
        CFG_NEAR_DISTANCE     = 3'd1,
        CFG_REARM_WAIT_MS     = 3'd2,
        CFG_POST_HOLD_MS      = 3'd3,
        CFG_BRAKE_PULSE_FAR   = 3'd4,
        CFG_BRAKE_PULSE_NEAR  = 3'd5,
        CFG_TRIGGER_SPEED     = 3'd6,
        CFG_OVERRIDE_PULSE    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DEC_PASS     = 3'd0,
        DEC_LOCKOUT  = 3'd1,
        DEC_TRIGGER  = 3'd2,
        DEC_HOLD     = 3'd3,
        DEC_OVERRIDE = 3'd4,
        DEC_STOP     = 3'd5,
        DEC_BLOCKED  = 3'd6
    } t_decision;

    typedef struct packed {
        logic [DistW-1:0]  obstacle_distance;
        logic [DistW-1:0]  near_distance;
        logic [15:0]       rearm_wait_ms;
        logic [15:0]       post_hold_ms;
        logic [PulseW-1:0] brake_pulse_far;
        logic [PulseW-1:0] brake_pulse_near;
        logic [15:0]       trigger_speed;
        logic [PulseW-1:0] override_pulse;
    } t_cfg;

    typedef struct packed {
        logic [PulseW-1:0]        drive_pulse;
        logic signed [SpeedW-1:0] wheel_speed;
        logic [DistW-1:0]         obstacle_range;
        logic [TimeW-1:0]         now_ms;
    } t_req;

    typedef struct packed {
        logic [PulseW-1:0] applied_pulse;
        logic              brake_engaged;
        t_decision         decision;
    } t_rsp;

endpackage

>>> hdl/obc_cfg_regs.sv
module obc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [obc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [obc_pkg::CfgDataW-1:0]  i_cfg_data,
    output obc_pkg::t_cfg                 o_cfg
);
    import obc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OBSTACLE_DISTANCE: n_cfg.obstacle_distance = i_cfg_data;
                CFG_NEAR_DISTANCE:     n_cfg.near_distance     = i_cfg_data;
                CFG_REARM_WAIT_MS:     n_cfg.rearm_wait_ms     = i_cfg_data;
                CFG_POST_HOLD_MS:      n_cfg.post_hold_ms      = i_cfg_data;
                CFG_BRAKE_PULSE_FAR:   n_cfg.brake_pulse_far   = i_cfg_data[PulseW-1:0];
                CFG_BRAKE_PULSE_NEAR:  n_cfg.brake_pulse_near  = i_cfg_data[PulseW-1:0];
                CFG_TRIGGER_SPEED:     n_cfg.trigger_speed     = i_cfg_data;
                CFG_OVERRIDE_PULSE:    n_cfg.override_pulse    = i_cfg_data[PulseW-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_distance <= RST_OBSTACLE_DISTANCE;
            r_cfg.near_distance     <= RST_NEAR_DISTANCE;
            r_cfg.rearm_wait_ms     <= RST_REARM_WAIT_MS;
            r_cfg.post_hold_ms      <= RST_POST_HOLD_MS;
            r_cfg.brake_pulse_far   <= RST_BRAKE_PULSE_FAR;
            r_cfg.brake_pulse_near  <= RST_BRAKE_PULSE_NEAR;
            r_cfg.trigger_speed     <= RST_TRIGGER_SPEED;
            r_cfg.override_pulse    <= RST_OVERRIDE_PULSE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/obc_core.sv
module obc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  obc_pkg::t_req i_req,
    input  obc_pkg::t_cfg i_cfg,
    output obc_pkg::t_rsp o_rsp
);
    import obc_pkg::*;

    logic              r_braking;
    logic [TimeW-1:0]  r_last_end;
    logic [TimeW-1:0]  r_hold_until;
    logic [PulseW-1:0] r_brake_pulse;

    logic              n_braking;
    logic [TimeW-1:0]  n_last_end;
    logic [TimeW-1:0]  n_hold_until;
    logic [PulseW-1:0] n_brake_pulse;

    logic              w_forward;
    logic              w_obstacle;
    logic [SpeedW:0]   w_abs_speed;
    logic              w_fast;
    logic              w_moving;
    logic              w_locked;
    logic              w_rearmed;
    logic [TimeW-1:0]  w_elapsed;
    logic [PulseW-1:0] w_new_pulse;
    logic              w_end_brake;

    always_comb begin
        w_forward  = i_req.drive_pulse < NEUTRAL_PULSE;
        w_obstacle = i_req.obstacle_range < i_cfg.obstacle_distance;
        // The most negative speed gives a magnitude of 2^15, hence one extra bit.
        if (i_req.wheel_speed[SpeedW-1]) begin
            w_abs_speed = (SpeedW+1)'(1 << SpeedW) - {1'b0, i_req.wheel_speed};
        end else begin
            w_abs_speed = {1'b0, i_req.wheel_speed};
        end
        w_fast      = w_abs_speed > {1'b0, i_cfg.trigger_speed};
        w_moving    = i_req.wheel_speed != '0;
        w_locked    = i_req.now_ms < r_hold_until;
        w_elapsed   = i_req.now_ms - r_last_end;
        w_rearmed   = w_elapsed > {16'd0, i_cfg.rearm_wait_ms};
        w_new_pulse = (i_req.obstacle_range < i_cfg.near_distance) ?
                      i_cfg.brake_pulse_near : i_cfg.brake_pulse_far;
    end

    // Priority chain of the braking rules.
    always_comb begin
        n_braking     = r_braking;
        n_brake_pulse = r_brake_pulse;
        w_end_brake   = 1'b0;
        o_rsp.applied_pulse = i_req.drive_pulse;
        o_rsp.decision      = DEC_PASS;
        if (!r_braking && w_locked && w_obstacle && w_forward) begin
            o_rsp.applied_pulse = NEUTRAL_PULSE;
            o_rsp.decision      = DEC_LOCKOUT;
        end else if (!r_braking && w_rearmed && w_obstacle && w_forward && w_fast) begin
            n_braking           = 1'b1;
            n_brake_pulse       = w_new_pulse;
            o_rsp.applied_pulse = w_new_pulse;
            o_rsp.decision      = DEC_TRIGGER;
        end else if (r_braking) begin
            if (i_req.drive_pulse > i_cfg.override_pulse) begin
                w_end_brake         = 1'b1;
                o_rsp.applied_pulse = NEUTRAL_PULSE;
                o_rsp.decision      = DEC_OVERRIDE;
            end else if (w_moving) begin
                o_rsp.applied_pulse = r_brake_pulse;
                o_rsp.decision      = DEC_HOLD;
            end else begin
                w_end_brake         = 1'b1;
                o_rsp.applied_pulse = NEUTRAL_PULSE;
                o_rsp.decision      = DEC_STOP;
            end
        end else if (w_obstacle && w_forward) begin
            o_rsp.applied_pulse = NEUTRAL_PULSE;
            o_rsp.decision      = DEC_BLOCKED;
        end
        if (w_end_brake) begin
            n_braking = 1'b0;
        end
        o_rsp.brake_engaged = n_braking;
        n_last_end   = w_end_brake ? i_req.now_ms : r_last_end;
        n_hold_until = w_end_brake ? (i_req.now_ms + {16'd0, i_cfg.post_hold_ms})
                                   : r_hold_until;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_braking     <= 1'b0;
            r_last_end    <= '0;
            r_hold_until  <= '0;
            r_brake_pulse <= RST_BRAKE_PULSE_FAR;
        end else if (i_fire) begin
            r_braking     <= n_braking;
            r_last_end    <= n_last_end;
            r_hold_until  <= n_hold_until;
            r_brake_pulse <= n_brake_pulse;
        end
    end

endmodule

>>> hdl/obstacle_brake_controller_unit.sv
// Obstacle brake controller. Each request carries a commanded drive pulse, a
// signed wheel speed, an obstacle range and a millisecond timestamp; each
// request yields exactly one response with the pulse to apply, the brake
// state after the step and a decision code. Requests are processed strictly
// in order, since every request may change the braking state seen by the
// next one. A request is captured in an input register, decided by one level
// of compare and add logic against the braking state, and the response is
// captured in a result register; the braking state is updated at the same
// edge. The block takes one request per clock cycle while responses are
// taken; a request passes the input register, then the result register,
// which lets a new request in while the previous response still waits to
// be taken. Configuration registers are written through the plain write
// port and are meant to be changed only while no request is in flight.
module obstacle_brake_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [obc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [obc_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  obc_pkg::t_req                 i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output obc_pkg::t_rsp                 o_rsp
);
    import obc_pkg::*;

    t_cfg w_cfg;
    t_rsp w_rsp;

    // Input register: holds one accepted request until it is decided.
    logic r_in_valid;
    t_req r_in;

    // Result register: holds one response until the consumer takes it.
    logic r_out_valid;
    t_rsp r_out;

    // The captured request is decided when the result register is free or
    // is being emptied in this same cycle.
    logic w_advance;

    assign w_advance   = r_in_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_in_valid || w_advance;

    obc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    obc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_in_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

>>> hdl/obc_checker.sv
module obc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_req_ready,
    input  logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    input  obc_pkg::t_rsp                 o_rsp
);
    import obc_pkg::*;

    // A response that is not taken stays on the port unchanged.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && o_req_ready)
        else $error("pipeline not empty after reset");

    // Every neutral decision drives the neutral pulse and leaves the brake off.
    a_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.decision == DEC_LOCKOUT || o_rsp.decision == DEC_OVERRIDE ||
                        o_rsp.decision == DEC_STOP || o_rsp.decision == DEC_BLOCKED)
        |-> o_rsp.applied_pulse == NEUTRAL_PULSE && !o_rsp.brake_engaged)
        else $error("neutral decision with wrong pulse or brake flag");

    // The brake flag is set exactly for trigger and hold decisions.
    a_brake_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.brake_engaged ==
            (o_rsp.decision == DEC_TRIGGER || o_rsp.decision == DEC_HOLD))
        else $error("brake flag does not match decision");

    // A hold may only follow a response that left the brake engaged.
    a_hold_after_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_ready && (o_rsp.decision == DEC_PASS ||
            o_rsp.decision == DEC_LOCKOUT || o_rsp.decision == DEC_BLOCKED ||
            o_rsp.decision == DEC_OVERRIDE || o_rsp.decision == DEC_STOP)
        |=> !(o_rsp_valid && o_rsp.decision == DEC_HOLD))
        else $error("hold without an engaged brake");

endmodule

bind obstacle_brake_controller_unit obc_checker u_obc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

>>> sim/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import obc_pkg::*;

    // The first stretch of cycles with no handshake on either side that this long ends the run.
    localparam int unsigned STALL_LIMIT = 2000;
    // Margin after the last owed response, so that the block is idle again.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned NUM_PHASES = 7;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic          i_req_valid;
    logic          o_req_ready;
    t_req          i_req;
    logic          o_rsp_valid;
    logic          i_rsp_ready = 1'b0;
    t_rsp          o_rsp;

    obstacle_brake_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Braking model. It keeps its own copy of the registers and of the
    // braking state, and is advanced once for every accepted request.
    // ------------------------------------------------------------------
    t_cfg         cfg;
    logic         braking;
    logic [31:0]  brake_end_ms;
    logic [31:0]  lockout_end_ms;
    logic [11:0]  held_pulse;

    // Responses still owed by the block, oldest first.
    t_rsp         pending_decisions [$];
    int unsigned  mismatch_count = 0;

    // Running millisecond clock that the random requests follow.
    logic [31:0]  clock_ms;

    function automatic void store_setting(input t_cfg_idx idx, input logic [15:0] v);
        case (idx)
            CFG_OBSTACLE_DISTANCE: cfg.obstacle_distance = v;
            CFG_NEAR_DISTANCE:     cfg.near_distance     = v;
            CFG_REARM_WAIT_MS:     cfg.rearm_wait_ms     = v;
            CFG_POST_HOLD_MS:      cfg.post_hold_ms      = v;
            CFG_BRAKE_PULSE_FAR:   cfg.brake_pulse_far   = v[11:0];
            CFG_BRAKE_PULSE_NEAR:  cfg.brake_pulse_near  = v[11:0];
            CFG_TRIGGER_SPEED:     cfg.trigger_speed     = v;
            CFG_OVERRIDE_PULSE:    cfg.override_pulse    = v[11:0];
            default: ;
        endcase
    endfunction

    // Works out the response to one request and moves the braking state on.
    // The rules are tried in a fixed order: lockout after a brake, brake
    // trigger, handling of a held brake, blocked forward drive, pass.
    function automatic t_rsp decide_brake(input t_req r);
        t_rsp        o;
        logic [16:0] speed_mag;
        logic        forward;
        logic        blocked;
        logic        released;
        forward  = r.drive_pulse < NEUTRAL_PULSE;
        blocked  = r.obstacle_range < cfg.obstacle_distance;
        released = 1'b0;
        // The most negative speed has a magnitude of 32768, one past the
        // largest positive speed, so the magnitude needs a seventeenth bit.
        speed_mag = r.wheel_speed[SpeedW-1] ? 17'h1_0000 - {1'b0, r.wheel_speed}
                                            : {1'b0, r.wheel_speed};
        o.applied_pulse = r.drive_pulse;
        o.decision      = DEC_PASS;
        // The lockout window is a plain compare, without any care for wrap.
        if (!braking && r.now_ms < lockout_end_ms && blocked && forward) begin
            o.applied_pulse = NEUTRAL_PULSE;
            o.decision      = DEC_LOCKOUT;
        end else if (!braking && (r.now_ms - brake_end_ms) > 32'(cfg.rearm_wait_ms)
                     && blocked && forward && speed_mag > {1'b0, cfg.trigger_speed}) begin
            braking    = 1'b1;
            held_pulse = (r.obstacle_range < cfg.near_distance) ? cfg.brake_pulse_near
                                                                : cfg.brake_pulse_far;
            o.applied_pulse = held_pulse;
            o.decision      = DEC_TRIGGER;
        end else if (braking) begin
            if (r.drive_pulse > cfg.override_pulse) begin
                released        = 1'b1;
                o.applied_pulse = NEUTRAL_PULSE;
                o.decision      = DEC_OVERRIDE;
            end else if (speed_mag != 17'd0) begin
                o.applied_pulse = held_pulse;
                o.decision      = DEC_HOLD;
            end else begin
                released        = 1'b1;
                o.applied_pulse = NEUTRAL_PULSE;
                o.decision      = DEC_STOP;
            end
        end else if (blocked && forward) begin
            o.applied_pulse = NEUTRAL_PULSE;
            o.decision      = DEC_BLOCKED;
        end
        if (released) begin
            braking        = 1'b0;
            brake_end_ms   = r.now_ms;
            lockout_end_ms = r.now_ms + 32'(cfg.post_hold_ms);
        end
        o.brake_engaged = braking;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Directed scenarios. Rows whose response is obvious carry it typed in;
    // the others are checked against the braking model.
    // ------------------------------------------------------------------
    typedef struct {
        t_req  req;
        bit    typed;
        t_rsp  rsp;
    } t_scenario;

    t_scenario brake_scenarios [$];

    function automatic void add_scenario(input logic [11:0] pulse, input int speed,
                                         input logic [15:0] range_in, input logic [31:0] t_ms,
                                         input bit typed = 1'b0,
                                         input logic [11:0] exp_pulse = '0,
                                         input logic exp_brake = 1'b0,
                                         input t_decision exp_dec = DEC_PASS);
        t_scenario s;
        s.req.drive_pulse    = pulse;
        s.req.wheel_speed    = 16'(speed);
        s.req.obstacle_range = range_in;
        s.req.now_ms         = t_ms;
        s.typed              = typed;
        s.rsp.applied_pulse  = exp_pulse;
        s.rsp.brake_engaged  = exp_brake;
        s.rsp.decision       = exp_dec;
        brake_scenarios.push_back(s);
    endfunction

    // ------------------------------------------------------------------
    // Random request generation.
    // ------------------------------------------------------------------
    function automatic logic [15:0] speed_of(input int unsigned mag);
        bit neg;
        // A magnitude of 32768 only exists as a negative speed.
        neg = (mag == 32768) || ($urandom_range(0, 1) == 1);
        return neg ? 16'(-int'(mag)) : 16'(mag);
    endfunction

    // Ranges cluster around the two distance thresholds of the current setting.
    function automatic logic [15:0] pick_range();
        int v;
        case ($urandom_range(0, 5))
            0:       v = int'($urandom_range(0, 65535));
            1, 2:    v = (cfg.obstacle_distance == 0) ? 0
                         : int'($urandom_range(0, cfg.obstacle_distance - 1));
            3:       v = int'(cfg.near_distance) + int'($urandom_range(0, 6)) - 3;
            4:       v = int'(cfg.obstacle_distance) + int'($urandom_range(0, 6)) - 3;
            default: v = int'($urandom_range(0, cfg.near_distance));
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 65535) begin
            v = 65535;
        end
        return 16'(v);
    endfunction

    // Most requests follow a braking episode: a forward command that meets an
    // obstacle at speed, then holds, then a release by override or standstill.
    // A fifth of them are pure noise, and the clock sometimes jumps anywhere
    // so that the wrap of the millisecond counter is reached.
    function automatic t_req make_request();
        t_req        r;
        int unsigned span;
        int unsigned lim;
        span = (int'(cfg.rearm_wait_ms) + int'(cfg.post_hold_ms)) / 3 + 20;
        case ($urandom_range(0, 19))
            0:       clock_ms = $urandom;
            1:       clock_ms += $urandom_range(0, 70000);
            2, 3:    clock_ms += $urandom_range(0, 5);
            default: clock_ms += $urandom_range(0, span);
        endcase
        r.now_ms         = clock_ms;
        r.drive_pulse    = 12'($urandom);
        r.wheel_speed    = 16'($urandom);
        r.obstacle_range = 16'($urandom);
        if ($urandom_range(0, 9) < 2) begin
            return r;
        end
        r.obstacle_range = pick_range();
        if (braking) begin
            case ($urandom_range(0, 9))
                0: begin
                    if (cfg.override_pulse < 12'd4095) begin
                        r.drive_pulse = 12'($urandom_range(cfg.override_pulse + 1, 4095));
                    end
                end
                1: r.wheel_speed = '0;
                default: begin
                    r.drive_pulse = 12'($urandom_range(0, cfg.override_pulse));
                    r.wheel_speed = speed_of($urandom_range(1, 32768));
                end
            endcase
        end else begin
            if ($urandom_range(0, 9) < 8) begin
                r.drive_pulse = 12'($urandom_range(0, NEUTRAL_PULSE - 1));
            end
            lim = cfg.trigger_speed;
            if ($urandom_range(0, 9) < 7) begin
                r.wheel_speed = speed_of((lim >= 32768) ? 32768
                                                        : $urandom_range(lim + 1, 32768));
            end else begin
                r.wheel_speed = speed_of($urandom_range(0, (lim > 32768) ? 32768 : lim));
            end
        end
        return r;
    endfunction

    // One register setting per phase. Phase zero keeps the reset values, two
    // phases take the low and high extremes, one makes braking trigger
    // easily, and the rest are random.
    function automatic void choose_settings(input int phase, output logic [15:0] s [8]);
        case (phase)
            2: begin
                foreach (s[k]) begin
                    s[k] = '0;
                end
            end
            3: begin
                s[CFG_OBSTACLE_DISTANCE] = 16'hFFFF;
                s[CFG_NEAR_DISTANCE]     = 16'hFFFF;
                s[CFG_REARM_WAIT_MS]     = 16'hFFFF;
                s[CFG_POST_HOLD_MS]      = 16'hFFFF;
                s[CFG_BRAKE_PULSE_FAR]   = 16'd4095;
                s[CFG_BRAKE_PULSE_NEAR]  = 16'd4095;
                s[CFG_TRIGGER_SPEED]     = 16'd32768;
                s[CFG_OVERRIDE_PULSE]    = 16'd4095;
            end
            4: begin
                s[CFG_OBSTACLE_DISTANCE] = 16'hFFFF;
                s[CFG_NEAR_DISTANCE]     = 16'($urandom);
                s[CFG_REARM_WAIT_MS]     = '0;
                s[CFG_POST_HOLD_MS]      = '0;
                s[CFG_BRAKE_PULSE_FAR]   = 16'($urandom_range(0, 4095));
                s[CFG_BRAKE_PULSE_NEAR]  = 16'($urandom_range(0, 4095));
                s[CFG_TRIGGER_SPEED]     = '0;
                s[CFG_OVERRIDE_PULSE]    = 16'($urandom_range(1500, 4095));
            end
            5: begin
                // Raw values; the pulse registers keep only their low 12 bits.
                foreach (s[k]) begin
                    s[k] = 16'($urandom);
                end
                s[CFG_TRIGGER_SPEED] = 16'($urandom_range(0, 32768));
            end
            default: begin
                s[CFG_OBSTACLE_DISTANCE] = 16'($urandom_range(50, 3000));
                s[CFG_NEAR_DISTANCE]     = 16'($urandom_range(0, 3000));
                s[CFG_REARM_WAIT_MS]     = 16'($urandom_range(0, 400));
                s[CFG_POST_HOLD_MS]      = 16'($urandom_range(0, 400));
                s[CFG_BRAKE_PULSE_FAR]   = 16'($urandom_range(1000, 2500));
                s[CFG_BRAKE_PULSE_NEAR]  = 16'($urandom_range(1000, 2500));
                s[CFG_TRIGGER_SPEED]     = 16'($urandom_range(0, 3000));
                s[CFG_OVERRIDE_PULSE]    = 16'($urandom_range(1400, 1700));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side. Everything here starts and ends at a falling edge.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    // Requests go out in bursts of random length. Between bursts valid drops
    // for a random gap, and about a quarter of the bursts follow on with no
    // gap at all. Valid that stays high between two requests is never lowered.
    task automatic send_request(input t_req r, input bit typed, input t_rsp typed_rsp);
        int unsigned gap;
        t_rsp        predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_req       <= r;
        i_req_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_req_ready);
        // The model always runs so that its state follows the block, even
        // where the expected response was typed in.
        predicted = decide_brake(r);
        pending_decisions.push_back(typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every owed response has arrived, plus
    // the block's latency so that it is idle for a register write.
    task automatic drain_responses();
        i_req_valid <= 1'b0;
        while (pending_decisions.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] s [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= s[i];
            @(posedge i_clk);
            store_setting(t_cfg_idx'(i), s[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side. The receiver switches between stall patterns every so
    // often: always ready, a coin toss, mostly stalled, or a fixed repeating
    // pattern that drops ready at regular intervals.
    // ------------------------------------------------------------------
    int unsigned stall_mode      = 0;
    int unsigned stall_mode_left = 0;
    int unsigned stall_tick      = 0;

    always @(negedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 150);
        end else begin
            stall_mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       i_rsp_ready <= 1'b1;
            1:       i_rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       i_rsp_ready <= ($urandom_range(0, 7) == 0);
            default: i_rsp_ready <= (stall_tick % 5 != 0);
        endcase
    end

    // Each accepted response is checked against the oldest owed one.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_decisions.size() == 0) begin
                $display("%0t: response with none owed: pulse %0d brake %0b decision %0d",
                         $time, o_rsp.applied_pulse, o_rsp.brake_engaged, o_rsp.decision);
                mismatch_count++;
            end else begin
                want = pending_decisions.pop_front();
                if (o_rsp.applied_pulse !== want.applied_pulse) begin
                    $display("%0t: applied_pulse expected %0d actual %0d",
                             $time, want.applied_pulse, o_rsp.applied_pulse);
                    mismatch_count++;
                end
                if (o_rsp.brake_engaged !== want.brake_engaged) begin
                    $display("%0t: brake_engaged expected %0b actual %0b",
                             $time, want.brake_engaged, o_rsp.brake_engaged);
                    mismatch_count++;
                end
                if (o_rsp.decision !== want.decision) begin
                    $display("%0t: decision expected %0d (%s) actual %0d",
                             $time, want.decision, want.decision.name(), o_rsp.decision);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a long stretch with no handshake on either side means the
    // block has hung or dropped a response.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    int unsigned phase_items [NUM_PHASES] = '{200, 300, 80, 80, 250, 200, 200};

    initial begin
        logic [15:0] setting [8];
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_OBSTACLE_DISTANCE;
        i_cfg_data  = '0;

        cfg.obstacle_distance = RST_OBSTACLE_DISTANCE;
        cfg.near_distance     = RST_NEAR_DISTANCE;
        cfg.rearm_wait_ms     = RST_REARM_WAIT_MS;
        cfg.post_hold_ms      = RST_POST_HOLD_MS;
        cfg.brake_pulse_far   = RST_BRAKE_PULSE_FAR;
        cfg.brake_pulse_near  = RST_BRAKE_PULSE_NEAR;
        cfg.trigger_speed     = RST_TRIGGER_SPEED;
        cfg.override_pulse    = RST_OVERRIDE_PULSE;
        braking        = 1'b0;
        brake_end_ms   = '0;
        lockout_end_ms = '0;
        held_pulse     = RST_BRAKE_PULSE_FAR;

        // Directed walk under the reset setting. Time moves forward so that
        // each rule is met in turn, then the clock is taken across the wrap.
        add_scenario(1500, 0, 1000, 0, 1'b1, NEUTRAL_PULSE, 1'b0, DEC_PASS);
        add_scenario(1400, 100, 200, 10, 1'b1, NEUTRAL_PULSE, 1'b0, DEC_BLOCKED);
        // Most negative speed at zero range: strong brake.
        add_scenario(0, -32768, 0, 2000, 1'b1, RST_BRAKE_PULSE_NEAR, 1'b1, DEC_TRIGGER);
        add_scenario(1500, 5, 100, 2010);
        add_scenario(4095, 5, 0, 2020, 1'b1, NEUTRAL_PULSE, 1'b0, DEC_OVERRIDE);
        add_scenario(1000, 1000, 10, 2100, 1'b1, NEUTRAL_PULSE, 1'b0, DEC_LOCKOUT);
        // Lockout has just run out, but the rearm delay has not.
        add_scenario(1000, 1000, 10, 2270);
        // One millisecond past the rearm delay, far obstacle.
        add_scenario(1499, 401, 200, 3021);
        add_scenario(1500, 0, 200, 3030);
        add_scenario(4095, 32767, 65535, 3100, 1'b1, 12'd4095, 1'b0, DEC_PASS);
        // Speed equal to the trigger speed does not brake.
        add_scenario(1499, 400, 299, 5000);
        add_scenario(1499, -401, 149, 5001);
        // A command equal to the override pulse keeps the brake.
        add_scenario(1510, -1, 149, 5002);
        add_scenario(1511, -1, 149, 5003);
        // Brake just before the counter wraps; the lockout end wraps past
        // zero and the rearm distance is taken across the wrap.
        add_scenario(1000, 500, 50, 32'hFFFF_FF00);
        add_scenario(1500, 0, 50, 32'hFFFF_FFF0);
        add_scenario(1000, 500, 50, 32'h0000_0010);
        add_scenario(1000, 500, 50, 32'h0000_0400);
        add_scenario(1500, 0, 50, 32'h0000_0410);
        // Range equal to the obstacle distance is not an obstacle.
        add_scenario(0, 32767, 300, 100000);
        add_scenario(1499, 0, 0, 200000);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (brake_scenarios[k]) begin
            send_request(brake_scenarios[k].req, brake_scenarios[k].typed,
                         brake_scenarios[k].rsp);
        end
        drain_responses();

        clock_ms = 32'd300000;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                choose_settings(phase, setting);
                load_settings(setting);
            end
            for (int n = 0; n < phase_items[phase]; n++) begin
                // Once in the run the sender holds off until the block has
                // answered everything it was given.
                if (phase == 1 && n == phase_items[phase] / 2) begin
                    drain_responses();
                end
                send_request(make_request(), 1'b0, '0);
            end
            drain_responses();
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/obc_pkg.sv
hdl/obc_cfg_regs.sv
hdl/obc_core.sv
hdl/obstacle_brake_controller_unit.sv
hdl/obc_checker.sv
sim/tb_top.sv
